/* sv/row_opaque_span_finder_defines.svh */
// ---------------------------------------------------------------------------
// Row opaque span finder assertion macros
// Shared concurrent assertion forms for the span finder checker.
// ---------------------------------------------------------------------------
`ifndef ROW_OPAQUE_SPAN_FINDER_DEFINES_SVH
`define ROW_OPAQUE_SPAN_FINDER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ROSF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("span finder assertion failed");

// Next-cycle implication, disabled during reset.
`define ROSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("span finder assertion failed");

`endif

/* sv/rosf_pkg.sv */
// ---------------------------------------------------------------------------
// Row opaque span finder package
// Beat types and fixed constants shared by the span finder modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rosf_pkg;

   localparam int ALPHA_W = 8;
   localparam int OUT_W = 13;
   localparam logic [ALPHA_W-1:0] ALPHA_CLEAR = 8'h00;
   localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic [ALPHA_W-1:0] alpha;
      logic               row_end;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] span_begin;
      logic [OUT_W-1:0] span_end;
      logic [OUT_W-1:0] opaque_begin;
      logic [OUT_W-1:0] opaque_end;
      logic             overflow;
   } rsp_type;

endpackage

/* sv/rosf_scan.sv */
// ---------------------------------------------------------------------------
// Row opaque span finder scan unit
// Per-row state and the combinational update that folds in one pixel and
// forms the row result when the last pixel arrives.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rosf_scan
   import rosf_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type pixel,
   output rsp_type result
);

   localparam int PW = $clog2(MAX_WIDTH + 1);
   localparam logic [PW-1:0] MAX_POS = PW'(MAX_WIDTH);

   logic [PW-1:0] position_ff, position_in;
   logic          seen_visible_ff, seen_visible_in;
   logic [PW-1:0] first_visible_ff, first_visible_in;
   logic [PW-1:0] last_visible_end_ff, last_visible_end_in;
   logic [PW-1:0] run_start_ff, run_start_in;
   logic [PW-1:0] best_start_ff, best_start_in;
   logic [PW-1:0] best_length_ff, best_length_in;
   logic [PW-1:0] best_end_ff, best_end_in;
   logic          overflowed_ff, overflowed_in;

   logic          active;
   logic          visible;
   logic          opaque;
   logic          better;
   logic [PW-1:0] next_pos;
   logic [PW-1:0] run_length;
   logic [PW-1:0] span_begin_w;
   logic [PW-1:0] span_end_w;

   always_comb begin
      active = position_ff < MAX_POS;
      visible = pixel.alpha != ALPHA_CLEAR;
      opaque = pixel.alpha == ALPHA_OPAQUE;
      next_pos = position_ff + PW'(1);
      run_length = next_pos - run_start_ff;
      better = active && opaque && (run_length > best_length_ff);

      position_in = active ? next_pos : position_ff;
      overflowed_in = overflowed_ff || !active;
      seen_visible_in = seen_visible_ff || (active && visible);
      first_visible_in = (active && visible && !seen_visible_ff) ? position_ff
                                                                  : first_visible_ff;
      last_visible_end_in = (active && visible) ? next_pos : last_visible_end_ff;
      run_start_in = (active && !opaque) ? next_pos : run_start_ff;
      best_start_in = better ? run_start_ff : best_start_ff;
      best_length_in = better ? run_length : best_length_ff;
      best_end_in = better ? next_pos : best_end_ff;

      span_begin_w = seen_visible_in ? first_visible_in : position_in;
      span_end_w = seen_visible_in ? last_visible_end_in : position_in;

      result.span_begin = OUT_W'(span_begin_w);
      result.span_end = OUT_W'(span_end_w);
      result.opaque_begin = (best_length_in != '0) ? OUT_W'(best_start_in)
                                                   : OUT_W'(span_begin_w);
      result.opaque_end = (best_length_in != '0) ? OUT_W'(best_end_in)
                                                 : OUT_W'(span_begin_w);
      result.overflow = overflowed_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && pixel.row_end)) begin
         position_ff <= '0;
         seen_visible_ff <= 1'b0;
         first_visible_ff <= '0;
         last_visible_end_ff <= '0;
         run_start_ff <= '0;
         best_start_ff <= '0;
         best_length_ff <= '0;
         best_end_ff <= '0;
         overflowed_ff <= 1'b0;
      end else if (step) begin
         position_ff <= position_in;
         seen_visible_ff <= seen_visible_in;
         first_visible_ff <= first_visible_in;
         last_visible_end_ff <= last_visible_end_in;
         run_start_ff <= run_start_in;
         best_start_ff <= best_start_in;
         best_length_ff <= best_length_in;
         best_end_ff <= best_end_in;
         overflowed_ff <= overflowed_in;
      end
   end

endmodule

/* sv/row_opaque_span_finder.sv */
// ---------------------------------------------------------------------------
// Row opaque span finder
// Pixels enter on the req channel as alpha bytes with a last-of-row flag.
// For each row one rsp beat reports the visible span (first and one past
// the last nonzero alpha) and the earliest longest run of alpha 255.
// One pixel beat is taken every cycle while req_ready is high. A beat is
// registered on entry and then folded into the row state; a last-of-row
// beat also loads the row result into the rsp register once it is free. The
// rate is set by the row state update behind the input register.
// Rows longer than MAX_WIDTH pixels saturate the position and set overflow.
// Reset clears the row state and both valid flags. While the rsp
// receiver stalls, pixel beats still flow into the row state; only a second
// last-of-row beat waits in the input register, and req_ready drops once
// that register cannot move.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module row_opaque_span_finder
   import rosf_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type scan_result;
   logic    out_free;
   logic    advance;

   rosf_scan #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .pixel (in_data_ff),
      .result(scan_result)
   );

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      advance = in_valid_ff && (!in_data_ff.row_end || out_free);
      req_ready = !in_valid_ff || advance;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance && in_data_ff.row_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance && in_data_ff.row_end) begin
         rsp_data_ff <= scan_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

/* sv/rosf_checker.sv */
// ---------------------------------------------------------------------------
// Row opaque span finder checker
// Port-level checks on result beats and on req_ready, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "row_opaque_span_finder_defines.svh"

module rosf_checker
   import rosf_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   localparam logic WIDE = MAX_WIDTH > 8191;

   logic rsp_stall;
   logic out_open;
   logic rsp_check;
   logic span_ordered;
   logic opaque_ordered;
   logic opaque_run;
   logic opaque_inside;

   always_comb begin
      rsp_stall = rsp_valid && !rsp_ready;
      out_open = !rsp_valid || rsp_ready;
      rsp_check = rsp_valid && !WIDE;
      span_ordered = rsp_data.span_begin <= rsp_data.span_end;
      opaque_ordered = rsp_data.opaque_begin <= rsp_data.opaque_end;
      opaque_run = rsp_check && (rsp_data.opaque_begin != rsp_data.opaque_end);
      opaque_inside = (rsp_data.opaque_begin >= rsp_data.span_begin) &&
                      (rsp_data.opaque_end <= rsp_data.span_end);
   end

   `ROSF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   `ROSF_ASSERT_IMPLY(a_req_open, clock, reset, out_open, req_ready)
   `ROSF_ASSERT_IMPLY(a_span_order, clock, reset, rsp_check, span_ordered)
   `ROSF_ASSERT_IMPLY(a_opaque_order, clock, reset, rsp_check, opaque_ordered)
   `ROSF_ASSERT_IMPLY(a_opaque_in_span, clock, reset, opaque_run, opaque_inside)

endmodule

bind row_opaque_span_finder rosf_checker #(
   .MAX_WIDTH(MAX_WIDTH)
) u_rosf_checker (
   .clock    (clock),
   .reset    (reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

/* sim/row_opaque_span_finder_tb.sv */
// ---------------------------------------------------------------------------
// Row opaque span finder testbench
// Streams rows of alpha beats into the span finder and checks every row
// result against a cycle-free model of the row scan kept in this bench.
// Covers hand-picked rows for the corner cases, random rows under four
// flow-control mixes, a long receiver hold-off that backs up the input,
// and a long row with two opaque runs of equal length.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module row_opaque_span_finder_tb;
   import rosf_pkg::*;

   localparam int ROW_LIMIT = 4096;
   localparam int LATENCY = 4;
   localparam int LONG_HOLD = 300;
   localparam int DRAIN_LIMIT = 5000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct = 0;
   int stall_pct = 0;
   logic long_hold = 1'b0;
   int held_cycles = 0;

   int mismatch_count = 0;
   int rows_sent = 0;
   int rows_checked = 0;
   int pixels_sent = 0;

   rsp_type row_result_q[$];

   logic [OUT_W-1:0] row_pos;
   logic [OUT_W-1:0] first_vis;
   logic [OUT_W-1:0] vis_end;
   logic [OUT_W-1:0] run_from;
   logic [OUT_W-1:0] best_from;
   logic [OUT_W-1:0] best_len;
   logic             seen_vis;
   logic             row_over;

   row_opaque_span_finder #(
      .MAX_WIDTH(ROW_LIMIT)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic clear_row_state();
      row_pos = '0;
      first_vis = '0;
      vis_end = '0;
      run_from = '0;
      best_from = '0;
      best_len = '0;
      seen_vis = 1'b0;
      row_over = 1'b0;
   endtask

   task automatic predict_row_span(input req_type px);
      rsp_type res;
      logic [OUT_W-1:0] idx;
      if (row_pos < ROW_LIMIT) begin
         idx = row_pos;
         if (px.alpha != ALPHA_CLEAR) begin
            if (!seen_vis) begin
               first_vis = idx;
               seen_vis = 1'b1;
            end
            vis_end = idx + 1'b1;
         end
         if (px.alpha == ALPHA_OPAQUE) begin
            if (idx + 1'b1 - run_from > best_len) begin
               best_from = run_from;
               best_len = idx + 1'b1 - run_from;
            end
         end else begin
            run_from = idx + 1'b1;
         end
         row_pos = idx + 1'b1;
      end else begin
         row_over = 1'b1;
      end
      if (px.row_end) begin
         res.span_begin = seen_vis ? first_vis : row_pos;
         res.span_end = seen_vis ? vis_end : row_pos;
         res.opaque_begin = res.span_begin;
         res.opaque_end = res.span_begin;
         if (best_len != '0) begin
            res.opaque_begin = best_from;
            res.opaque_end = best_from + best_len;
         end
         res.overflow = row_over;
         row_result_q = {row_result_q, res};
         rows_sent++;
         clear_row_state();
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at row %0d: %s got %0d, expected %0d", rows_checked, what, got, want);
      mismatch_count++;
   endtask

   // Sends one pixel beat; valid stays high into the next call unless a gap is drawn.
   task automatic send_pixel(input logic [ALPHA_W-1:0] alpha, input logic last);
      req_type px;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      px.alpha = alpha;
      px.row_end = last;
      req_valid <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (!req_ready);
      predict_row_span(px);
      pixels_sent++;
   endtask

   task automatic send_random_row(input int len);
      int style;
      int sel;
      logic [ALPHA_W-1:0] alpha;
      style = $urandom_range(9);
      for (int i = 0; i < len; i++) begin
         sel = $urandom_range(99);
         case (style)
            0: alpha = ALPHA_OPAQUE;
            1: alpha = ALPHA_CLEAR;
            2: alpha = ALPHA_W'($urandom_range(255));
            default: begin
               if (sel < 45) alpha = ALPHA_OPAQUE;
               else if (sel < 75) alpha = ALPHA_CLEAR;
               else alpha = ALPHA_W'($urandom_range(255));
            end
         endcase
         send_pixel(alpha, i == len - 1);
      end
   endtask

   // Stops offering beats until every pending row result is back.
   task automatic wait_rows_done();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (row_result_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (row_result_q.size() != 0) begin
         report_mismatch("rows never answered", row_result_q.size(), 0);
         row_result_q.delete();
      end
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic test_directed_rows();
      send_idle_pct = 0;
      stall_pct = 0;
      send_pixel(ALPHA_CLEAR, 1'b1);
      send_pixel(ALPHA_OPAQUE, 1'b1);
      send_pixel(8'h01, 1'b1);
      send_pixel(ALPHA_CLEAR, 1'b0);
      send_pixel(8'h80, 1'b0);
      send_pixel(ALPHA_CLEAR, 1'b1);
      send_pixel(ALPHA_OPAQUE, 1'b0);
      send_pixel(ALPHA_OPAQUE, 1'b0);
      send_pixel(ALPHA_CLEAR, 1'b0);
      send_pixel(ALPHA_OPAQUE, 1'b0);
      send_pixel(ALPHA_OPAQUE, 1'b1);
      send_pixel(ALPHA_OPAQUE, 1'b0);
      send_pixel(8'hFE, 1'b0);
      send_pixel(ALPHA_OPAQUE, 1'b0);
      send_pixel(ALPHA_OPAQUE, 1'b0);
      send_pixel(8'h7F, 1'b0);
      send_pixel(ALPHA_OPAQUE, 1'b0);
      send_pixel(ALPHA_OPAQUE, 1'b0);
      send_pixel(ALPHA_OPAQUE, 1'b0);
      send_pixel(ALPHA_CLEAR, 1'b1);
      send_pixel(8'hAA, 1'b0);
      send_pixel(8'h55, 1'b0);
      send_pixel(ALPHA_CLEAR, 1'b0);
      send_pixel(ALPHA_CLEAR, 1'b1);
      wait_rows_done();
   endtask

   task automatic test_random_rows(input int idle_pct, input int stall_in_pct,
                                   input int pixel_budget);
      int start_pixels;
      send_idle_pct = idle_pct;
      stall_pct = stall_in_pct;
      start_pixels = pixels_sent;
      while (pixels_sent - start_pixels < pixel_budget) begin
         if ($urandom_range(9) == 0) send_random_row($urandom_range(25, 80));
         else send_random_row($urandom_range(1, 12));
      end
      wait_rows_done();
   endtask

   task automatic test_receiver_hold_off();
      send_idle_pct = 0;
      stall_pct = 0;
      long_hold <= 1'b1;
      fork
         begin
            repeat (10) send_random_row($urandom_range(1, 4));
         end
         begin
            while (held_cycles < LONG_HOLD) @(posedge clock);
            long_hold <= 1'b0;
         end
      join
      wait_rows_done();
   endtask

   task automatic test_long_rows();
      send_idle_pct = 0;
      stall_pct = 10;
      for (int i = 0; i < 100; i++) begin
         if (i < 10) send_pixel(ALPHA_CLEAR, 1'b0);
         else if (i < 50) send_pixel(ALPHA_OPAQUE, 1'b0);
         else if (i < 60) send_pixel(8'h40, 1'b0);
         else send_pixel(ALPHA_OPAQUE, i == 99);
      end
      send_random_row(6);
      wait_rows_done();
   endtask

   always @(posedge clock) begin
      if (long_hold) begin
         rsp_ready <= 1'b0;
         held_cycles <= held_cycles + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
         held_cycles <= 0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (row_result_q.size() == 0) begin
            report_mismatch("rsp beat with no row pending", 1, 0);
         end else begin
            want = row_result_q.pop_front();
            if (rsp_data.span_begin !== want.span_begin)
               report_mismatch("span_begin", int'(rsp_data.span_begin),
                               int'(want.span_begin));
            if (rsp_data.span_end !== want.span_end)
               report_mismatch("span_end", int'(rsp_data.span_end), int'(want.span_end));
            if (rsp_data.opaque_begin !== want.opaque_begin)
               report_mismatch("opaque_begin", int'(rsp_data.opaque_begin),
                               int'(want.opaque_begin));
            if (rsp_data.opaque_end !== want.opaque_end)
               report_mismatch("opaque_end", int'(rsp_data.opaque_end),
                               int'(want.opaque_end));
            if (rsp_data.overflow !== want.overflow)
               report_mismatch("overflow", int'(rsp_data.overflow), int'(want.overflow));
         end
         rows_checked++;
      end
   end

   initial begin
      clear_row_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_rows();
      test_random_rows(0, 0, 110);
      test_random_rows(75, 0, 110);
      test_random_rows(0, 75, 110);
      test_random_rows(16, 16, 110);
      test_receiver_hold_off();
      test_long_rows();
      $display("Sent %0d rows in %0d pixel beats and checked %0d row results.",
               rows_sent, pixels_sent, rows_checked);
      $display("Phases: corner rows, random rows under four flow mixes, a %0d-cycle hold-off, %s",
               LONG_HOLD, "and a long row with tied opaque runs.");
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d rows outstanding.", row_result_q.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
